[hw/rtl/md5_pkg.sv]
// Shared types, constants and step tables for the MD5 digest engine.
package md5_pkg;

  typedef logic [31:0] word_t;

  localparam word_t CHAIN_INIT [4] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

  localparam logic [6:0] BLOCK_BYTES = 7'd64;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [3:0] LEN_LO_WORD = 4'd14;
  localparam logic [3:0] LEN_HI_WORD = 4'd15;
  localparam logic [5:0] LAST_STEP   = 6'd63;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } dig_t;

  typedef struct packed {
    logic [6:0]  fill;
    logic        pad80;
    logic        len_en;
    logic [63:0] bit_len;
  } pad_ctrl_t;

  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] lo;
    logic [3:0] g;
    begin
      lo = i[3:0];
      unique case (i[5:4])
        2'd0: g = lo;
        2'd1: g = 4'(lo * 4'd5 + 4'd1);
        2'd2: g = 4'(lo * 4'd3 + 4'd5);
        2'd3: g = 4'(lo * 4'd7);
      endcase
      return g;
    end
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    begin
      unique case ({i[5:4], i[1:0]})
        4'h0: s = 5'd7;
        4'h1: s = 5'd12;
        4'h2: s = 5'd17;
        4'h3: s = 5'd22;
        4'h4: s = 5'd5;
        4'h5: s = 5'd9;
        4'h6: s = 5'd14;
        4'h7: s = 5'd20;
        4'h8: s = 5'd4;
        4'h9: s = 5'd11;
        4'ha: s = 5'd16;
        4'hb: s = 5'd23;
        4'hc: s = 5'd6;
        4'hd: s = 5'd10;
        4'he: s = 5'd15;
        4'hf: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    begin
      unique case (i)
        6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
        6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
        6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
        6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
        6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

endpackage

[hw/rtl/md5_msg_buf.sv]
// Block buffer memory with padding and length insertion on the read side.
module md5_msg_buf (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [5:0]               wr_addr,
  input  logic [7:0]               wr_byte,
  input  logic [3:0]               rd_addr,
  input  md5_pkg::pad_ctrl_t      pad,
  output md5_pkg::word_t           word
);

  md5_pkg::word_t mem [16];
  md5_pkg::word_t rd_data;
  logic [3:0]     rd_word;
  logic [6:0]     pos;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
    rd_data <= mem[rd_addr];
    rd_word <= rd_addr;
  end

  // bytes past the fill point read as the pad marker or zero
  always_comb begin
    pos  = '0;
    word = '0;
    for (int k = 0; k < 4; k++) begin
      pos = {1'b0, rd_word, 2'(k)};
      if (pos < pad.fill) begin
        word[8*k +: 8] = rd_data[8*k +: 8];
      end else if (pos == pad.fill && pad.pad80) begin
        word[8*k +: 8] = md5_pkg::PAD_BYTE;
      end else begin
        word[8*k +: 8] = 8'h00;
      end
    end
    if (pad.len_en && rd_word == md5_pkg::LEN_LO_WORD) begin
      word = pad.bit_len[31:0];
    end else if (pad.len_en && rd_word == md5_pkg::LEN_HI_WORD) begin
      word = pad.bit_len[63:32];
    end
  end

endmodule

[hw/rtl/md5_step.sv]
// One MD5 compression step: round function, add constant and message word, rotate, add b.
module md5_round_core (
  input  md5_pkg::word_t a,
  input  md5_pkg::word_t b,
  input  md5_pkg::word_t c,
  input  md5_pkg::word_t d,
  input  md5_pkg::word_t m,
  input  logic [5:0]     step,
  output md5_pkg::word_t b_next
);

  md5_pkg::word_t f;
  md5_pkg::word_t sum;
  logic [63:0]    dbl;

  always_comb begin
    unique case (step[5:4])
      2'd0: f = d ^ (b & (c ^ d));
      2'd1: f = c ^ (d & (b ^ c));
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
    endcase
    sum    = a + f + md5_pkg::round_k(step) + m;
    dbl    = {sum, sum} << md5_pkg::rot_amt(step);
    b_next = b + dbl[63:32];
  end

endmodule

[hw/rtl/md5_message_digest_top.sv]
// MD5 digest engine top: byte intake, step sequencer, chaining state, digest output.
//
//  channel | dir | payload         | transfer
//  msg     | in  | md5_pkg::msg_t  | msg_valid & !msg_stall
//  dig     | out | md5_pkg::dig_t  | dig_valid & !dig_stall
//
// A byte that neither fills the block nor ends the message leaves the engine idle.
// Each compression runs a memory read prime, 64 steps, then a chain add.
// End of message adds one or two compressions, then four digest transfers.
// msg_stall is high while not idle: through each compression and digest output.
// Synchronous reset loads the initial chain and clears the byte count; no clearing pass.
module md5_message_digest_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          msg_valid,
  output logic          msg_stall,
  input  md5_pkg::msg_t msg,
  output logic          dig_valid,
  input  logic          dig_stall,
  output md5_pkg::dig_t dig
);

  typedef enum logic [2:0] {S_IDLE, S_PRIME, S_STEP, S_ADD, S_OUT} state_t;
  typedef enum logic [1:0] {BLK_FULL, BLK_PAD, BLK_LAST} blk_t;

  state_t              state;
  blk_t                kind;
  logic [5:0]          step;
  md5_pkg::word_t      a, b, c, d;
  md5_pkg::word_t      chain [4];
  logic [60:0]         byte_count;
  logic [60:0]         cnt_next;
  logic [6:0]          fill;
  logic                pad80;
  logic                len_en;
  logic                eom_pending;
  logic [1:0]          idx;
  logic [5:0]          fin_pos;
  logic                wr_en;
  logic [3:0]          rd_addr;
  md5_pkg::word_t      m_word;
  md5_pkg::word_t      b_next;
  md5_pkg::pad_ctrl_t  pad;

  assign msg_stall = (state != S_IDLE);
  assign dig_valid = (state == S_OUT);
  assign dig.digest_word = chain[idx];
  assign dig.word_index  = idx;
  assign dig.last_word   = (idx == 2'd3);

  assign cnt_next = byte_count + 61'd1;
  assign fin_pos  = (state == S_IDLE && msg.byte_present) ? cnt_next[5:0] : byte_count[5:0];
  assign wr_en    = msg_valid && !msg_stall && msg.byte_present;
  assign rd_addr  = md5_pkg::msg_index((state == S_STEP) ? 6'(step + 6'd1) : 6'd0);

  assign pad.fill    = fill;
  assign pad.pad80   = pad80;
  assign pad.len_en  = len_en;
  assign pad.bit_len = {byte_count, 3'b000};

  md5_msg_buf u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (byte_count[5:0]),
    .wr_byte (msg.data_byte),
    .rd_addr (rd_addr),
    .pad     (pad),
    .word    (m_word)
  );

  md5_round_core u_step (
    .a      (a),
    .b      (b),
    .c      (c),
    .d      (d),
    .m      (m_word),
    .step   (step),
    .b_next (b_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      kind        <= BLK_FULL;
      step        <= '0;
      chain       <= md5_pkg::CHAIN_INIT;
      byte_count  <= '0;
      fill        <= '0;
      pad80       <= 1'b0;
      len_en      <= 1'b0;
      eom_pending <= 1'b0;
      idx         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (msg_valid) begin
            if (msg.byte_present) begin
              byte_count <= cnt_next;
            end
            if (msg.byte_present && cnt_next[5:0] == 6'd0) begin
              kind        <= BLK_FULL;
              fill        <= md5_pkg::BLOCK_BYTES;
              pad80       <= 1'b0;
              len_en      <= 1'b0;
              eom_pending <= msg.end_of_message;
              state       <= S_PRIME;
            end else if (msg.end_of_message) begin
              fill   <= {1'b0, fin_pos};
              pad80  <= 1'b1;
              len_en <= (fin_pos < md5_pkg::LEN_POS);
              kind   <= (fin_pos < md5_pkg::LEN_POS) ? BLK_LAST : BLK_PAD;
              state  <= S_PRIME;
            end
          end
        end
        S_PRIME: begin
          a     <= chain[0];
          b     <= chain[1];
          c     <= chain[2];
          d     <= chain[3];
          step  <= '0;
          state <= S_STEP;
        end
        S_STEP: begin
          a    <= d;
          b    <= b_next;
          c    <= b;
          d    <= c;
          step <= step + 6'd1;
          if (step == md5_pkg::LAST_STEP) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          unique case (kind)
            BLK_FULL: begin
              if (eom_pending) begin
                eom_pending <= 1'b0;
                fill        <= {1'b0, fin_pos};
                pad80       <= 1'b1;
                len_en      <= (fin_pos < md5_pkg::LEN_POS);
                kind        <= (fin_pos < md5_pkg::LEN_POS) ? BLK_LAST : BLK_PAD;
                state       <= S_PRIME;
              end else begin
                state <= S_IDLE;
              end
            end
            BLK_PAD: begin
              fill   <= '0;
              pad80  <= 1'b0;
              len_en <= 1'b1;
              kind   <= BLK_LAST;
              state  <= S_PRIME;
            end
            BLK_LAST: begin
              idx   <= '0;
              state <= S_OUT;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_OUT: begin
          if (!dig_stall) begin
            idx <= idx + 2'd1;
            if (idx == 2'd3) begin
              chain      <= md5_pkg::CHAIN_INIT;
              byte_count <= '0;
              state      <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_intake_during_digest: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> msg_stall)
    else $error("input taken while digest pending");

  a_restart_after_digest: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && !dig_stall && dig.last_word) |=>
      (chain[0] == md5_pkg::CHAIN_INIT[0] && byte_count == 61'd0 && state == S_IDLE))
    else $error("chain not restarted after digest");

  a_full_block_unpadded: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> ((fill == md5_pkg::BLOCK_BYTES) != (pad80 || len_en)))
    else $error("padding mixed with full block");

  a_partial_byte_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (msg_valid && !msg_stall && msg.byte_present && !msg.end_of_message &&
     cnt_next[5:0] != 6'd0) |=> (state == S_IDLE))
    else $error("partial block byte started compression");

endmodule
